// ===== hw/rtl/twp_pkg.sv =====
`default_nettype none

package twp_pkg;

	// Fixed widths of the transaction fields
	localparam int VALUE_W = 8;
	localparam int PIVOT_W = 8;
	localparam logic [PIVOT_W-1:0] PIVOT_RESET = 8'd1;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} twp_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value_res;
		logic               last_res;
		logic               overflowed;
	} twp_result_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_EVAL,
		ST_SWAP,
		ST_EMIT_RD,
		ST_EMIT_LD
	} twp_state_t;

	// Controller -> datapath
	typedef struct packed {
		logic load;     // store incoming element
		logic fetch;    // read element at mid
		logic eval;     // classify current element against pivot
		logic swap;     // finish high-side exchange
		logic emit_rd;  // read element k
		logic emit_ld;  // load result register
		logic finish;   // clear block state
	} twp_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic last;
		logic cur_lt;
		logic cur_gt;
		logic step_more;
		logic swap_more;
		logic emit_last;
		logic out_free;
	} twp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/twp_ram.sv =====
`default_nettype none

module twp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/twp_ctrl.sv =====
`default_nettype none

module twp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire twp_pkg::twp_sts_t sts,
	output twp_pkg::twp_cmd_t      cmd
);

	import twp_pkg::*;

	twp_state_t state_q;
	twp_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (item_valid && sts.last) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (sts.cur_gt) begin
					state_d = ST_SWAP;
				end else if (sts.step_more) begin
					state_d = ST_FETCH;
				end else begin
					state_d = ST_EMIT_RD;
				end
			end
			ST_SWAP: begin
				state_d = sts.swap_more ? ST_EVAL : ST_EMIT_RD;
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (sts.out_free) begin
					state_d = sts.emit_last ? ST_LOAD : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// Outputs
	always_comb begin
		item_ready = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_LOAD: begin
				item_ready = 1'b1;
				cmd.load   = item_valid;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
			end
			ST_SWAP: begin
				cmd.swap = 1'b1;
			end
			ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
			end
			ST_EMIT_LD: begin
				cmd.emit_ld = sts.out_free;
				cmd.finish  = sts.out_free && sts.emit_last;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/twp_dp.sv =====
`default_nettype none

module twp_dp #(
	parameter int DEPTH     = 64,
	parameter int ELEM_BITS = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire twp_pkg::twp_cmd_t                    cmd,
	output twp_pkg::twp_sts_t                         sts,
	input  wire twp_pkg::twp_item_t                   item,
	input  wire logic                                 cfg_we,
	input  wire logic [twp_pkg::PIVOT_W-1:0]          cfg_wdata,
	output logic                                      result_valid,
	input  wire logic                                 result_ready,
	output twp_pkg::twp_result_t                      result
);

	import twp_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int PW = $clog2(DEPTH + 1);

	logic [PW-1:0]        count_q;
	logic                 ovf_q;
	logic [PW-1:0]        lo_q;
	logic [PW-1:0]        mid_q;
	logic [PW-1:0]        hi_q;
	logic [PW-1:0]        k_q;
	logic [ELEM_BITS-1:0] cur_q;
	logic                 use_ram_q;
	logic [PIVOT_W-1:0]   pivot_q;
	logic                 res_valid_q;
	twp_result_t          res_q;

	logic                 count_full;
	logic [PW-1:0]        count_n;
	logic [PW-1:0]        hi_dec;
	logic [ELEM_BITS-1:0] p_elem;
	logic [ELEM_BITS-1:0] cur;
	logic [ELEM_BITS-1:0] elem_out;
	logic                 in_region;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [ELEM_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [ELEM_BITS-1:0] ram_rdata;

	assign count_full = (count_q == PW'(DEPTH));
	assign count_n    = count_full ? count_q : count_q + PW'(1);
	assign hi_dec     = hi_q - PW'(1);
	assign p_elem     = ELEM_BITS'(pivot_q);
	assign cur        = use_ram_q ? ram_rdata : cur_q;
	// [lo, hi) holds only pivot-equal elements once the walk ends; the walk never writes them
	assign in_region  = (k_q >= lo_q) && (k_q < hi_q);
	assign elem_out   = in_region ? p_elem : ram_rdata;

	assign sts.last      = item.last;
	assign sts.cur_lt    = cur < p_elem;
	assign sts.cur_gt    = cur > p_elem;
	assign sts.step_more = (mid_q + PW'(1)) < hi_q;
	assign sts.swap_more = mid_q < hi_q;
	assign sts.emit_last = (k_q + PW'(1)) == count_q;
	assign sts.out_free  = !res_valid_q || result_ready;

	// Store write/read port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = ELEM_BITS'(item.value);
		priority if (cmd.load) begin
			ram_we = !count_full;
		end else if (cmd.eval) begin
			ram_we    = sts.cur_lt;
			ram_waddr = lo_q[AW-1:0];
			ram_wdata = cur;
		end else if (cmd.swap) begin
			ram_we    = 1'b1;
			ram_waddr = hi_q[AW-1:0];
			ram_wdata = cur_q;
		end else begin
			ram_we = 1'b0;
		end
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = mid_q[AW-1:0];
		priority if (cmd.fetch) begin
			ram_re = 1'b1;
		end else if (cmd.eval) begin
			ram_re    = sts.cur_gt;
			ram_raddr = hi_dec[AW-1:0];
		end else if (cmd.emit_rd) begin
			ram_re    = 1'b1;
			ram_raddr = k_q[AW-1:0];
		end else begin
			ram_re = 1'b0;
		end
	end

	twp_ram #(
		.WIDTH (ELEM_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			lo_q        <= '0;
			mid_q       <= '0;
			hi_q        <= '0;
			k_q         <= '0;
			use_ram_q   <= 1'b0;
			pivot_q     <= PIVOT_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pivot_q <= cfg_wdata;
			end

			if (cmd.load) begin
				if (count_full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_n;
				end
				if (item.last) begin
					lo_q  <= '0;
					mid_q <= '0;
					hi_q  <= count_n;
					k_q   <= '0;
				end
			end

			if (cmd.fetch) begin
				use_ram_q <= 1'b1;
			end

			if (cmd.eval) begin
				use_ram_q <= 1'b0;
				if (sts.cur_lt) begin
					lo_q  <= lo_q + PW'(1);
					mid_q <= mid_q + PW'(1);
				end else if (sts.cur_gt) begin
					hi_q <= hi_dec;
				end else begin
					mid_q <= mid_q + PW'(1);
				end
			end

			if (cmd.emit_ld) begin
				k_q         <= k_q + PW'(1);
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end

			if (cmd.finish) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			cur_q <= cur;
		end else if (cmd.swap) begin
			cur_q <= ram_rdata;
		end
		if (cmd.emit_ld) begin
			res_q.value_res  <= VALUE_W'(elem_out);
			res_q.last_res   <= sts.emit_last;
			res_q.overflowed <= sts.emit_last && ovf_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Walk pointers stay ordered inside the block
	a_ptr_order: assert property (@(posedge clk) disable iff (!arst_n)
		(lo_q <= mid_q) && (mid_q <= hi_q) && (hi_q <= PW'(DEPTH)))
		else $error("partition pointers out of order");

	// Result register is only loaded when it is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_ld |-> (!res_valid_q || result_ready))
		else $error("result overwritten while pending");

	// Block state cleared after the final result is loaded
	a_block_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (count_q == '0) && !ovf_q && res_valid_q && res_q.last_res)
		else $error("block state not cleared after final result");

	// Emit never runs past the stored element count
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_rd |-> (k_q < count_q))
		else $error("emit index beyond element count");

endmodule

`default_nettype wire

// ===== hw/rtl/three_way_partition_core.sv =====
// Channel   Signals                                    Transaction
// item      item_valid / item_ready / item             one element, last closes the block
// result    result_valid / result_ready / result       one partitioned element
// cfg       cfg_we / cfg_wdata                         pivot write, no wait
//
// Load: one element per cycle. Partition walk: each element takes a store read then a
// classify, or a classify then an exchange read/write, paced by the single read and
// single write port of the element store. Emit: each element takes a store read, then
// a result register load, which waits while a result is pending and result_ready is low.
// No clearing pass after reset.
// item_ready is high only while loading; a pending result does not block loading.
`default_nettype none

module three_way_partition_core #(
	parameter int DEPTH     = 64,  // element store entries
	parameter int ELEM_BITS = 8    // stored element and compare width
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// Input elements
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire twp_pkg::twp_item_t           item,
	// Partitioned elements
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output twp_pkg::twp_result_t              result,
	// Pivot register
	input  wire logic                         cfg_we,
	input  wire logic [twp_pkg::PIVOT_W-1:0]  cfg_wdata
);

	import twp_pkg::*;

	twp_cmd_t cmd;
	twp_sts_t sts;

	// Sequencer: load, Dutch-flag walk, emit
	twp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Store, lo/mid/hi pointers, pivot and result register.
	// The run of pivot-equal elements is tracked by pointers only and
	// regenerated from the pivot on emit, so each step needs at most one write.
	twp_dp #(
		.DEPTH     (DEPTH),
		.ELEM_BITS (ELEM_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire
